// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pmt_pkg.sv
// Types and constants of the PS/2 mouse packet tracker.
package pmt_pkg;

  localparam int IN_DATA_BITS  = 16;
  localparam int OUT_DATA_BITS = 32;
  localparam int CFG_DATA_BITS = 11;
  localparam int CURSOR_BITS   = 10;
  localparam int DIVISOR_BITS  = 8;
  localparam int MAG_BITS      = 9;

  // status and header bits
  localparam int STAT_READY_BIT = 0;
  localparam int STAT_AUX_BIT   = 5;
  localparam int HDR_XSIGN_BIT  = 4;
  localparam int HDR_YSIGN_BIT  = 5;

  // out_tdata bit positions
  localparam int OB_CURSOR_X  = 0;
  localparam int OB_CURSOR_Y  = 10;
  localparam int OB_LEFT_HELD = 20;
  localparam int OB_RIGHT_HELD = 21;
  localparam int OB_MID_HELD  = 22;
  localparam int OB_LEFT_PRS  = 23;
  localparam int OB_LEFT_REL  = 24;
  localparam int OB_RIGHT_PRS = 25;
  localparam int OB_RIGHT_REL = 26;
  localparam int OB_MID_PRS   = 27;
  localparam int OB_MID_REL   = 28;
  localparam int OB_USED      = 29;

  localparam logic [CFG_DATA_BITS-1:0] WIDTH_RST  = 11'd320;
  localparam logic [CFG_DATA_BITS-1:0] HEIGHT_RST = 11'd200;
  localparam logic [DIVISOR_BITS-1:0]  YDIV_RST   = 8'd100;

  localparam int STEP_BITS = 4;
  localparam logic [STEP_BITS-1:0] DIV_LAST = 4'd8;  // nine quotient bits

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_Y_DIVISOR     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PKT_HDR = 2'd0,
    PKT_XD  = 2'd1,
    PKT_YD  = 2'd2
  } pkt_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_XUPD,
    ST_YUPD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_DIV,
    OP_X,
    OP_Y
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load_out;
  } ctrl_t;

endpackage

// File: rtl/pmt_seq.sv
// Sequencer: steps the shared adder through divide, X and Y updates.
module pmt_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pkt_done,
  input  logic           out_free,
  output logic           in_ready,
  output pmt_pkg::ctrl_t ctrl
);
  import pmt_pkg::*;

  state_t                 state_r, state_nxt;
  logic [STEP_BITS-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (pkt_done) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = ST_XUPD;
      end
      ST_XUPD: state_nxt = ST_YUPD;
      ST_YUPD: state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctrl.op       = OP_NONE;
    ctrl.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_DIV:  ctrl.op = OP_DIV;
      ST_XUPD: ctrl.op = OP_X;
      ST_YUPD: ctrl.op = OP_Y;
      ST_OUT:  ctrl.load_out = out_free;
      default: in_ready = 1'b0;
    endcase
  end

endmodule

// File: rtl/pmt_dp.sv
// Datapath: packet capture, shared add/subtract unit, divider and clamped cursor.
module pmt_dp #(
  parameter int COORD_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 byte_take,
  input  logic [7:0]                           data_byte,
  input  pmt_pkg::ctrl_t                       ctrl,
  input  logic [pmt_pkg::CFG_DATA_BITS-1:0]    screen_width,
  input  logic [pmt_pkg::CFG_DATA_BITS-1:0]    screen_height,
  input  logic [pmt_pkg::DIVISOR_BITS-1:0]     y_divisor,
  output logic                                 pkt_done,
  output logic [pmt_pkg::CURSOR_BITS-1:0]      cursor_x,
  output logic [pmt_pkg::CURSOR_BITS-1:0]      cursor_y,
  output logic [2:0]                           btn_now,
  output logic [2:0]                           btn_was
);
  import pmt_pkg::*;

  localparam int AW = COORD_BITS + 2;
  localparam int OW = (COORD_BITS > CURSOR_BITS) ? COORD_BITS : CURSOR_BITS;
  localparam logic [AW-1:0]         TOP_LIM = AW'(1) << COORD_BITS;
  localparam logic [COORD_BITS-1:0] POSX_RST = COORD_BITS'(100);

  pkt_idx_t                    byte_idx_r, byte_idx_nxt;
  logic [7:0]                  hdr_r, hdr_nxt;
  logic [7:0]                  xd_r, xd_nxt;
  logic [2:0]                  btn_r, btn_nxt;
  logic [2:0]                  prev_r, prev_nxt;
  logic [COORD_BITS-1:0]       pos_x_r, pos_x_nxt;
  logic [COORD_BITS-1:0]       pos_y_r, pos_y_nxt;
  logic [DIVISOR_BITS-1:0]     rem_r, rem_nxt;
  logic [MAG_BITS-1:0]         quo_r, quo_nxt;
  logic                        yneg_r, yneg_nxt;

  logic [AW-1:0]               op_a, op_b, b_eff, sum, lim_ext, lim_eff, max_v;
  logic [AW-1:0]               dx_ext;
  logic [CFG_DATA_BITS-1:0]    lim;
  logic [COORD_BITS-1:0]       clamped;
  logic [DIVISOR_BITS-1:0]     div_eff;
  logic [MAG_BITS-1:0]         dy_mag;
  logic [MAG_BITS-1:0]         trial_a;
  logic                        sub;
  logic [OW-1:0]               px_w, py_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r <= PKT_HDR;
      btn_r      <= '0;
      pos_x_r    <= POSX_RST;
      pos_y_r    <= '0;
    end else begin
      byte_idx_r <= byte_idx_nxt;
      btn_r      <= btn_nxt;
      pos_x_r    <= pos_x_nxt;
      pos_y_r    <= pos_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r  <= hdr_nxt;
    xd_r   <= xd_nxt;
    prev_r <= prev_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    yneg_r <= yneg_nxt;
  end

  assign pkt_done = byte_take && (byte_idx_r == PKT_YD);
  assign div_eff  = (y_divisor == '0) ? DIVISOR_BITS'(1) : y_divisor;
  assign dx_ext   = AW'($signed({hdr_r[HDR_XSIGN_BIT], xd_r}));
  assign dy_mag   = hdr_r[HDR_YSIGN_BIT] ? (9'd256 - {1'b0, data_byte}) : {1'b0, data_byte};
  assign trial_a  = {rem_r, quo_r[MAG_BITS-1]};

  // shared adder
  always_comb begin
    op_a = '0;
    op_b = '0;
    sub  = 1'b0;
    unique case (ctrl.op)
      OP_DIV: begin
        op_a = AW'(trial_a);
        op_b = AW'(div_eff);
        sub  = 1'b1;
      end
      OP_X: begin
        op_a = AW'(pos_x_r);
        op_b = dx_ext;
      end
      OP_Y: begin
        op_a = AW'(pos_y_r);
        op_b = AW'(quo_r);
        sub  = !yneg_r;
      end
      default: sub = 1'b0;
    endcase
    b_eff = sub ? ~op_b : op_b;
    sum   = op_a + b_eff + AW'(sub);
  end

  // clamp to 0 .. limit-1
  always_comb begin
    lim     = (ctrl.op == OP_Y) ? screen_height : screen_width;
    lim_ext = AW'(lim);
    if (lim == '0)             lim_eff = AW'(1);
    else if (lim_ext > TOP_LIM) lim_eff = TOP_LIM;
    else                       lim_eff = lim_ext;
    max_v = lim_eff - AW'(1);
    if (sum[AW-1])         clamped = '0;
    else if (sum > max_v)  clamped = max_v[COORD_BITS-1:0];
    else                   clamped = sum[COORD_BITS-1:0];
  end

  always_comb begin
    byte_idx_nxt = byte_idx_r;
    hdr_nxt      = hdr_r;
    xd_nxt       = xd_r;
    btn_nxt      = btn_r;
    prev_nxt     = prev_r;
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    yneg_nxt     = yneg_r;
    if (byte_take) begin
      unique case (byte_idx_r)
        PKT_HDR: begin
          hdr_nxt      = data_byte;
          byte_idx_nxt = PKT_XD;
        end
        PKT_XD: begin
          xd_nxt       = data_byte;
          byte_idx_nxt = PKT_YD;
        end
        PKT_YD: begin
          byte_idx_nxt = PKT_HDR;
          prev_nxt     = btn_r;
          btn_nxt      = hdr_r[2:0];
          yneg_nxt     = hdr_r[HDR_YSIGN_BIT];
          quo_nxt      = dy_mag;
          rem_nxt      = '0;
        end
        default: byte_idx_nxt = PKT_HDR;
      endcase
    end
    case (ctrl.op)
      OP_DIV: begin
        if (!sum[AW-1]) begin
          rem_nxt = sum[DIVISOR_BITS-1:0];
          quo_nxt = {quo_r[MAG_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = trial_a[DIVISOR_BITS-1:0];
          quo_nxt = {quo_r[MAG_BITS-2:0], 1'b0};
        end
      end
      OP_X:    pos_x_nxt = clamped;
      OP_Y:    pos_y_nxt = clamped;
      default: ;
    endcase
  end

  assign px_w     = OW'(pos_x_r);
  assign py_w     = OW'(pos_y_r);
  assign cursor_x = px_w[CURSOR_BITS-1:0];
  assign cursor_y = py_w[CURSOR_BITS-1:0];
  assign btn_now  = btn_r;
  assign btn_was  = prev_r;

endmodule

// File: rtl/ps2_mouse_packet_tracker.sv
// Top level: PS/2 mouse packet tracker with config registers and output register.
// in_tready stays high for the header and X bytes.
// The third byte holds in_tready low through its steps, and while an earlier word still waits:
// nine divide steps, X and Y clamped updates on one shared adder, then the result load.
// The result is registered onto out_tdata in the load step, once the output is free.
// Synchronous active-low reset: cursor (100,0), buttons released, 320x200, divisor 100.
module ps2_mouse_packet_tracker #(
  parameter int COORD_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pmt_pkg::IN_DATA_BITS-1:0]    in_tdata,   // ctrl_status, data_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // cursor_x, cursor_y, left_held, right_held, middle_held, left_pressed,
  // left_released, right_pressed, right_released, middle_pressed, middle_released
  output logic [pmt_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_addr,
  input  logic [pmt_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import pmt_pkg::*;

  logic [CFG_DATA_BITS-1:0]  width_r, width_nxt;
  logic [CFG_DATA_BITS-1:0]  height_r, height_nxt;
  logic [DIVISOR_BITS-1:0]   ydiv_r, ydiv_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_DATA_BITS-1:0]  out_data_r, out_data_nxt;

  logic [7:0]                ctrl_status, data_byte;
  logic                      byte_take, pkt_done, out_free;
  ctrl_t                     ctrl;
  logic [CURSOR_BITS-1:0]    cursor_x, cursor_y;
  logic [2:0]                btn_now, btn_was;
  logic [2:0]                prs, rel;

  assign ctrl_status = in_tdata[7:0];
  assign data_byte   = in_tdata[15:8];
  assign byte_take   = in_tvalid && in_tready
                       && ctrl_status[STAT_READY_BIT] && ctrl_status[STAT_AUX_BIT];
  assign out_free    = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      ydiv_r      <= YDIV_RST;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      ydiv_r      <= ydiv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    ydiv_nxt   = ydiv_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SCREEN_WIDTH:  width_nxt  = cfg_wdata;
        CFG_SCREEN_HEIGHT: height_nxt = cfg_wdata;
        CFG_Y_DIVISOR:     ydiv_nxt   = cfg_wdata[DIVISOR_BITS-1:0];
        default:           ydiv_nxt   = ydiv_r;
      endcase
    end
  end

  pmt_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .pkt_done (pkt_done),
    .out_free (out_free),
    .in_ready (in_tready),
    .ctrl     (ctrl)
  );

  pmt_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_take     (byte_take),
    .data_byte     (data_byte),
    .ctrl          (ctrl),
    .screen_width  (width_r),
    .screen_height (height_r),
    .y_divisor     (ydiv_r),
    .pkt_done      (pkt_done),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .btn_now       (btn_now),
    .btn_was       (btn_was)
  );

  assign prs = btn_now & ~btn_was;
  assign rel = btn_was & ~btn_now;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (ctrl.load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[OB_CURSOR_X +: CURSOR_BITS] = cursor_x;
      out_data_nxt[OB_CURSOR_Y +: CURSOR_BITS] = cursor_y;
      out_data_nxt[OB_LEFT_HELD]  = btn_now[0];
      out_data_nxt[OB_RIGHT_HELD] = btn_now[1];
      out_data_nxt[OB_MID_HELD]   = btn_now[2];
      out_data_nxt[OB_LEFT_PRS]   = prs[0];
      out_data_nxt[OB_LEFT_REL]   = rel[0];
      out_data_nxt[OB_RIGHT_PRS]  = prs[1];
      out_data_nxt[OB_RIGHT_REL]  = rel[1];
      out_data_nxt[OB_MID_PRS]    = prs[2];
      out_data_nxt[OB_MID_REL]    = rel[2];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/pmt_checker.sv
// Port-level checks on the tracker's result channel, bound to the top level.
`include "assert_macros.svh"

module pmt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [pmt_pkg::OUT_DATA_BITS-1:0] out_tdata
);
  import pmt_pkg::*;

  `ASSERT_CLK_RST(a_rst_clears, !rst_n |=> !out_tvalid, "result valid after reset")
  `ASSERT_CLK(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled word changed")
  `ASSERT_CLK(a_pad_zero, out_tvalid |-> out_tdata[OUT_DATA_BITS-1:OB_USED] == '0, "pad bits set")
  `ASSERT_CLK(a_press_held, out_tvalid |-> (!out_tdata[OB_LEFT_PRS] || out_tdata[OB_LEFT_HELD]) && (!out_tdata[OB_RIGHT_PRS] || out_tdata[OB_RIGHT_HELD]) && (!out_tdata[OB_MID_PRS] || out_tdata[OB_MID_HELD]), "press without held")
  `ASSERT_CLK(a_rel_free, out_tvalid |-> !(out_tdata[OB_LEFT_REL] && out_tdata[OB_LEFT_HELD]) && !(out_tdata[OB_RIGHT_REL] && out_tdata[OB_RIGHT_HELD]) && !(out_tdata[OB_MID_REL] && out_tdata[OB_MID_HELD]), "release while held")

endmodule

bind ps2_mouse_packet_tracker pmt_checker u_pmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: dv/tb_ps2_mouse_packet_tracker.sv
// Self-checking testbench for the PS/2 mouse packet tracker: cursor and button prediction.
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_tracker;
  import pmt_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int NUM_SEGMENTS   = 10;
  localparam int SEGMENT_BYTES  = 82;

  typedef struct {
    logic [CURSOR_BITS-1:0] x;
    logic [CURSOR_BITS-1:0] y;
    logic l_held, r_held, m_held;
    logic l_prs, l_rel, r_prs, r_rel, m_prs, m_rel;
  } cursor_report_t;

  class cursor_predictor;
    int unsigned width, height, ydiv;
    pkt_idx_t    slot;
    logic [7:0]  hdr, xbyte;
    logic [2:0]  held;
    int          px, py;
    cursor_report_t reports[$];
    int errors, checked, taken, dropped;

    function new();
      width  = WIDTH_RST;
      height = HEIGHT_RST;
      ydiv   = YDIV_RST;
      slot   = PKT_HDR;
      hdr    = '0;
      xbyte  = '0;
      held   = '0;
      px     = 100;
      py     = 0;
    endfunction

    function void set_limits(int unsigned w, int unsigned h, int unsigned d);
      width  = w & 11'h7FF;
      height = h & 11'h7FF;
      ydiv   = d & 8'hFF;
    endfunction

    function int clamp(int v, int unsigned lim);
      int unsigned top;
      top = 1 << CURSOR_BITS;
      if (lim == 0) lim = 1;
      if (lim > top) lim = top;
      if (v < 0) return 0;
      if (v > int'(lim - 1)) return int'(lim - 1);
      return v;
    endfunction

    function void note_byte(logic [7:0] st, logic [7:0] d);
      logic [2:0] prev;
      int dx, dy, dv;
      cursor_report_t r;
      if (!(st[STAT_READY_BIT] && st[STAT_AUX_BIT])) begin
        dropped++;
        return;
      end
      taken++;
      case (slot)
        PKT_HDR: begin
          hdr  = d;
          slot = PKT_XD;
        end
        PKT_XD: begin
          xbyte = d;
          slot  = PKT_YD;
        end
        default: begin
          slot = PKT_HDR;
          prev = held;
          held = hdr[2:0];
          dx = hdr[HDR_XSIGN_BIT] ? int'(xbyte) - 256 : int'(xbyte);
          dy = hdr[HDR_YSIGN_BIT] ? int'(d) - 256 : int'(d);
          dv = (ydiv == 0) ? 1 : int'(ydiv);
          px = clamp(px + dx, width);
          py = clamp(py - dy / dv, height);
          r.x      = px[CURSOR_BITS-1:0];
          r.y      = py[CURSOR_BITS-1:0];
          r.l_held = held[0];
          r.r_held = held[1];
          r.m_held = held[2];
          r.l_prs  = held[0] & ~prev[0];
          r.l_rel  = prev[0] & ~held[0];
          r.r_prs  = held[1] & ~prev[1];
          r.r_rel  = prev[1] & ~held[1];
          r.m_prs  = held[2] & ~prev[2];
          r.m_rel  = prev[2] & ~held[2];
          reports.push_back(r);
        end
      endcase
    endfunction

    function void cmp(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_report(logic [OUT_DATA_BITS-1:0] w);
      cursor_report_t e;
      if (reports.size() == 0) begin
        $error("cursor report with none expected: %h", w);
        errors++;
        return;
      end
      e = reports.pop_front();
      checked++;
      cmp("cursor_x", e.x, w[OB_CURSOR_Y-1:OB_CURSOR_X]);
      cmp("cursor_y", e.y, w[OB_LEFT_HELD-1:OB_CURSOR_Y]);
      cmp("left_held", e.l_held, w[OB_LEFT_HELD]);
      cmp("right_held", e.r_held, w[OB_RIGHT_HELD]);
      cmp("middle_held", e.m_held, w[OB_MID_HELD]);
      cmp("left_pressed", e.l_prs, w[OB_LEFT_PRS]);
      cmp("left_released", e.l_rel, w[OB_LEFT_REL]);
      cmp("right_pressed", e.r_prs, w[OB_RIGHT_PRS]);
      cmp("right_released", e.r_rel, w[OB_RIGHT_REL]);
      cmp("middle_pressed", e.m_prs, w[OB_MID_PRS]);
      cmp("middle_released", e.m_rel, w[OB_MID_REL]);
    endfunction

    function int outstanding();
      return reports.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;   // ctrl_status, data_byte
  logic                     out_tvalid;
  logic                     out_tready;
  // cursor_x, cursor_y, left_held, right_held, middle_held, left_pressed,
  // left_released, right_pressed, right_released, middle_pressed, middle_released
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     cfg_we;
  logic [1:0]               cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  cursor_predictor tracker;
  int  snd_idle_pct;
  int  rcv_stall_pct;
  bit  hold_req;
  int  quiet_cycles;
  int  settings_used;

  ps2_mouse_packet_tracker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (in_tvalid && in_tready)
        tracker.note_byte(in_tdata[7:0], in_tdata[15:8]);
      if (out_tvalid && out_tready)
        tracker.check_report(out_tdata);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_ps2_mouse_packet_tracker: done, errors");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [7:0] st, input logic [7:0] d);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d, st};
    do @(posedge clk); while (!in_tready);
  endtask

  // drop in_tvalid and let the monitor see the last accepted word first
  task automatic wait_reports_done(input int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_screen(input int unsigned w, input int unsigned h,
                              input int unsigned d);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SCREEN_WIDTH;
    cfg_wdata <= w[CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_addr  <= CFG_SCREEN_HEIGHT;
    cfg_wdata <= h[CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_addr  <= CFG_Y_DIVISOR;
    cfg_wdata <= d[CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_limits(w, h, d);
    settings_used++;
  endtask

  task automatic pick_screen(input int seg, output int unsigned w,
                             output int unsigned h, output int unsigned d);
    case (seg)
      0: begin w = 1024; h = 1024; d = 1;   end
      1: begin w = 0;    h = 0;    d = 0;   end
      2: begin w = 2047; h = 2047; d = 255; end
      3: begin w = 1;    h = 1;    d = 1;   end
      4: begin w = 640;  h = 480;  d = 2;   end
      6: begin w = 1024; h = 0;    d = 7;   end
      8: begin w = 2047; h = 1024; d = 0;   end
      9: begin w = 320;  h = 200;  d = 100; end
      default: begin
        w = $urandom_range(1024, 1);
        h = $urandom_range(1024, 1);
        d = $urandom_range(255, 1);
      end
    endcase
  endtask

  initial begin
    int unsigned w, h, d;
    int          good;
    logic [7:0]  st;

    tracker       = new();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_req      = 1'b0;
    quiet_cycles  = 0;
    settings_used = 1;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset limits: dropped words, clamps at both ends, sign bits
    send_word(8'h00, 8'hFF);
    send_word(8'h01, 8'hFF);
    send_word(8'h20, 8'h00);
    send_word(8'hDE, 8'h55);
    send_word(8'h21, 8'h09);           // left, bit 3 set
    send_word(8'hFF, 8'hFF);
    send_word(8'h21, 8'h00);
    send_word(8'h21, 8'hF2);           // right, both signs, overflow bits
    send_word(8'h21, 8'h00);
    send_word(8'hFF, 8'h00);
    send_word(8'h21, 8'h04);           // middle, large up move
    send_word(8'h21, 8'h01);
    send_word(8'h21, 8'hFF);
    send_word(8'h21, 8'h07);           // all held, drops mid-packet
    send_word(8'h01, 8'h80);
    send_word(8'h21, 8'h10);
    send_word(8'h20, 8'h33);
    send_word(8'h21, 8'h80);
    send_word(8'h21, 8'h28);           // all released, y sign
    send_word(8'h21, 8'h00);
    send_word(8'h21, 8'h01);
    wait_reports_done(SETTLE_CYCLES);

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      pick_screen(seg, w, h, d);
      write_screen(w, h, d);
      case (seg % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 69; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 69; end
        default: begin snd_idle_pct = 17; rcv_stall_pct = 17; end
      endcase
      if (seg == 4) hold_req = 1'b1;
      good = 0;
      while (good < SEGMENT_BYTES) begin
        if (seg == 6 && good == SEGMENT_BYTES / 2) begin
          wait_reports_done(0);
          good++;
        end
        if ($urandom_range(5) == 0)
          st = 8'($urandom_range(255));
        else
          st = 8'($urandom_range(255)) | 8'h21;
        send_word(st, 8'($urandom_range(255)));
        if (st[STAT_READY_BIT] && st[STAT_AUX_BIT]) good++;
      end
      wait_reports_done(SETTLE_CYCLES);
    end

    $display("%0d bytes taken into packets, %0d dropped, %0d cursor reports checked",
             tracker.taken, tracker.dropped, tracker.checked);
    $display("covered %0d register settings incl. zero and oversized limits, four idle mixes",
             settings_used);
    if (tracker.errors == 0) begin
      $display("tb_ps2_mouse_packet_tracker: done, clean");
    end else begin
      $display("tb_ps2_mouse_packet_tracker: done, errors");
    end
    $finish;
  end

endmodule
